// File: rtl/spi_mbe_pkg.sv
// ============================================================================
// spi_mbe_pkg
// Shared types and constants for the SPI master byte engine.
// ============================================================================
package spi_mbe_pkg;

    // Bus command codes as they arrive on the input channel
    localparam logic [1:0] CMD_WRITE_DATA  = 2'd0;
    localparam logic [1:0] CMD_READ_DATA   = 2'd1;
    localparam logic [1:0] CMD_READ_STATUS = 2'd2;
    localparam logic [1:0] CMD_TICK        = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPI_MODE  = 2'd0;
    localparam logic [1:0] CFG_BAUD_DIV  = 2'd1;
    localparam logic [1:0] CFG_LSB_LEAD  = 2'd2;
    localparam logic [1:0] CFG_ENABLE    = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_STATUS,
        OP_TICK
    } t_op;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic       miso_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       tx_empty;
        logic       rx_not_empty;
        logic       busy_res;
        logic       sck_out;
        logic       mosi_out;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [7:0] tx_byte;
        logic       miso_in;
    } t_q_entry;

    typedef struct packed {
        logic [1:0] spi_mode;      // bit0 CPHA, bit1 CPOL
        logic [2:0] baud_div_code;
        logic       lsb_lead;
        logic       enable;
    } t_cfg;

endpackage

// File: rtl/spi_mbe_front.sv
// ============================================================================
// spi_mbe_front
// Input side: takes bus beats and classifies them into queue entries.
// ============================================================================
module spi_mbe_front
    import spi_mbe_pkg::*;
(
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_q_ready,
    output logic     o_q_push,
    output t_q_entry o_q_entry
);

    t_op op;

    always_comb begin
        unique case (i_item.command)
            CMD_WRITE_DATA:  op = OP_WRITE;
            CMD_READ_DATA:   op = OP_READ;
            CMD_READ_STATUS: op = OP_STATUS;
            CMD_TICK:        op = OP_TICK;
            default:         op = OP_STATUS;
        endcase
    end

    assign o_ready   = i_q_ready;
    assign o_q_push  = i_valid && i_q_ready;
    // drop payload bits that the operation never looks at
    assign o_q_entry = '{op:      op,
                         tx_byte: (op == OP_WRITE) ? i_item.tx_byte : 8'd0,
                         miso_in: (op == OP_TICK) ? i_item.miso_in : 1'b0};

endmodule

// File: rtl/spi_mbe_queue.sv
// ============================================================================
// spi_mbe_queue
// Short FIFO that decouples the classifier from the execution stage.
// ============================================================================
module spi_mbe_queue
    import spi_mbe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_push_ready,
    input  t_q_entry i_entry,
    output logic     o_pop_valid,
    input  logic     i_pop,
    output t_q_entry o_entry
);

    t_q_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0]   r_count, n_count;
    logic                     do_push, do_pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_entry      = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QUEUE_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: rtl/spi_mbe_back.sv
// ============================================================================
// spi_mbe_back
// Execution stage: buffers, shifter, SCK prescaler and the result register.
// ============================================================================
module spi_mbe_back
    import spi_mbe_pkg::*;
#(
    parameter int FRAME_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_q_entry  i_q_entry,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int BL_W = $clog2(FRAME_BITS + 1);

    logic [7:0]            r_tx_hold, n_tx_hold;
    logic                  r_tx_full, n_tx_full;
    logic [FRAME_BITS-1:0] r_shifter, n_shifter;
    logic [FRAME_BITS-1:0] r_rx_hold, n_rx_hold;
    logic                  r_rx_full, n_rx_full;
    logic [BL_W-1:0]       r_bits_left, n_bits_left;
    logic [7:0]            r_prescale, n_prescale;
    logic                  r_sck, n_sck;
    logic                  r_shifting, n_shifting;
    logic                  r_mosi, n_mosi;
    t_out_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  cpol, cpha;
    logic [FRAME_BITS-1:0] load_val, sampled, sh_after;
    logic [BL_W-1:0]       bl_dec, bl_after;
    logic                  bit_cur, bit_load;
    logic [7:0]            pc_inc, pc_limit, rd;
    logic                  pop;

    assign cpol     = i_cfg.spi_mode[1];
    assign cpha     = i_cfg.spi_mode[0];
    assign load_val = FRAME_BITS'(r_tx_hold);
    assign bit_cur  = i_cfg.lsb_lead ? r_shifter[0] : r_shifter[FRAME_BITS-1];
    assign bit_load = i_cfg.lsb_lead ? load_val[0] : load_val[FRAME_BITS-1];
    assign sampled  = i_cfg.lsb_lead ? {i_q_entry.miso_in, r_shifter[FRAME_BITS-1:1]}
                                     : {r_shifter[FRAME_BITS-2:0], i_q_entry.miso_in};
    assign bl_dec   = (r_bits_left == '0) ? '0 : r_bits_left - BL_W'(1);
    assign sh_after = cpha ? sampled : r_shifter;
    assign bl_after = cpha ? bl_dec : r_bits_left;
    assign pc_inc   = r_prescale + 8'd1;
    assign pc_limit = 8'd1 << i_cfg.baud_div_code;

    // execute the head entry once the result register can take it
    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_tx_hold   = r_tx_hold;
        n_tx_full   = r_tx_full;
        n_shifter   = r_shifter;
        n_rx_hold   = r_rx_hold;
        n_rx_full   = r_rx_full;
        n_bits_left = r_bits_left;
        n_prescale  = r_prescale;
        n_sck       = r_sck;
        n_shifting  = r_shifting;
        n_mosi      = r_mosi;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        rd          = 8'd0;
        if (pop) begin
            unique case (i_q_entry.op)
                OP_WRITE: begin
                    if (!r_tx_full) begin
                        n_tx_hold = i_q_entry.tx_byte;
                        n_tx_full = 1'b1;
                    end
                end
                OP_READ: begin
                    rd        = 8'(r_rx_hold);
                    n_rx_full = 1'b0;
                end
                OP_STATUS: begin
                end
                OP_TICK: begin
                    if (!i_cfg.enable) begin
                        // drop any frame in flight, keep the buffered byte
                        n_shifting  = 1'b0;
                        n_bits_left = '0;
                        n_prescale  = 8'd0;
                    end else if (!r_shifting) begin
                        if (r_tx_full) begin
                            n_shifter   = load_val;
                            n_tx_full   = 1'b0;
                            n_shifting  = 1'b1;
                            n_bits_left = BL_W'(FRAME_BITS);
                            n_prescale  = 8'd0;
                            n_sck       = cpol;
                            if (!cpha) begin
                                n_mosi = bit_load;
                            end
                        end
                    end else if (pc_inc >= pc_limit) begin
                        n_prescale = 8'd0;
                        n_sck      = ~r_sck;
                        if (r_sck == cpol) begin
                            // leading edge
                            if (cpha) begin
                                n_mosi = bit_cur;
                            end else begin
                                n_shifter   = sampled;
                                n_bits_left = bl_dec;
                            end
                        end else begin
                            // trailing edge
                            if (cpha) begin
                                n_shifter   = sampled;
                                n_bits_left = bl_dec;
                            end else if (r_bits_left != '0) begin
                                n_mosi = bit_cur;
                            end
                            if (bl_after == '0) begin
                                n_rx_hold  = sh_after;
                                n_rx_full  = 1'b1;
                                n_shifting = 1'b0;
                            end
                        end
                    end else begin
                        n_prescale = pc_inc;
                    end
                end
                default: begin
                end
            endcase
            if (!n_shifting) begin
                n_sck = cpol;
            end
            n_out = '{read_byte:    rd,
                      tx_empty:     ~n_tx_full,
                      rx_not_empty: n_rx_full,
                      busy_res:     n_shifting,
                      sck_out:      n_sck,
                      mosi_out:     n_mosi};
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_hold   <= 8'd0;
            r_tx_full   <= 1'b0;
            r_shifter   <= '0;
            r_rx_hold   <= '0;
            r_rx_full   <= 1'b0;
            r_bits_left <= '0;
            r_prescale  <= 8'd0;
            r_sck       <= 1'b0;
            r_shifting  <= 1'b0;
            r_mosi      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx_hold   <= n_tx_hold;
            r_tx_full   <= n_tx_full;
            r_shifter   <= n_shifter;
            r_rx_hold   <= n_rx_hold;
            r_rx_full   <= n_rx_full;
            r_bits_left <= n_bits_left;
            r_prescale  <= n_prescale;
            r_sck       <= n_sck;
            r_shifting  <= n_shifting;
            r_mosi      <= n_mosi;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// File: rtl/spi_master_byte_engine_top.sv
// ============================================================================
// spi_master_byte_engine_top
// SPI master with data/status register commands and tick-driven shifting.
// ============================================================================
// Every accepted beat (data write, data read, status read or clock tick)
// returns exactly one status beat, in order. The block takes one beat per
// clock while the queue has room; a beat is held in the queue and then in
// the result register before its result is offered. The execution stage
// retires one queued command per cycle into its result register while it
// is empty or being taken; a two-entry queue before that stage absorbs
// output stalls. SCK toggles once every 2^baud_div_code tick commands, and
// a frame of FRAME_BITS bits needs 2 * FRAME_BITS toggles. Configuration
// must be written by the user through the plain write port while no beat
// is in flight; the block itself does not enforce this.
module spi_master_byte_engine_top
    import spi_mbe_pkg::*;
#(
    parameter int FRAME_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     q_ready, q_push, q_valid, q_pop;
    t_q_entry push_entry, head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPI_MODE:  r_cfg.spi_mode      <= i_cfg_data[1:0];
                CFG_BAUD_DIV:  r_cfg.baud_div_code <= i_cfg_data[2:0];
                CFG_LSB_LEAD:  r_cfg.lsb_lead      <= i_cfg_data[0];
                CFG_ENABLE:    r_cfg.enable        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    spi_mbe_front u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_data),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_entry (push_entry)
    );

    spi_mbe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .o_push_ready (q_ready),
        .i_entry      (push_entry),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_entry      (head_entry)
    );

    spi_mbe_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_entry (head_entry),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

// File: rtl/spi_mbe_chk.sv
// ============================================================================
// spi_mbe_chk
// Port-level checks for the SPI master byte engine.
// ============================================================================
module spi_mbe_chk
    import spi_mbe_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // result side clears on reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // queue is empty after reset, so the input side is open
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("stalled result beat changed");

endmodule

bind spi_master_byte_engine_top spi_mbe_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
